// ----- rtl/i64a_pkg.sv -----
// ----------------------------------------------------------------------------
// i64a_pkg: shared types for the 64-bit integer alu
// action codes, request and response beats, and the per-stage cell record
// ----------------------------------------------------------------------------
`default_nettype none

package i64a_pkg;

	localparam int unsigned DATA_W    = 64;
	localparam int unsigned HALF_W    = DATA_W / 2;
	localparam int unsigned DIV_STEPS = DATA_W;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_SUB  = 5'd1,
		OP_MUL  = 5'd2,
		OP_SDIV = 5'd3,
		OP_SMOD = 5'd4,
		OP_AND  = 5'd5,
		OP_OR   = 5'd6,
		OP_XOR  = 5'd7,
		OP_NOT  = 5'd8,
		OP_SSHL = 5'd9,
		OP_SSHR = 5'd10,
		OP_ROL  = 5'd11,
		OP_ROR  = 5'd12,
		OP_SCMP = 5'd13,
		OP_UMUL = 5'd14,
		OP_UDIV = 5'd15,
		OP_UMOD = 5'd16,
		OP_USHL = 5'd17,
		OP_USHR = 5'd18,
		OP_UCMP = 5'd19
	} op_t;

	typedef struct packed {
		logic [4:0]        action;
		logic [DATA_W-1:0] operand_a;
		logic [DATA_W-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic              div_by_zero;
	} rsp_t;

	// one stage of the divider chain, with the other results riding along
	typedef struct packed {
		logic              valid;
		logic [4:0]        action;
		logic              dz;
		logic              is_div;
		logic              qneg;
		logic              rneg;
		logic [DATA_W-1:0] res;
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] dq;
		logic [DATA_W-1:0] dvs;
		logic [DATA_W-1:0] mlo;
		logic [HALF_W-1:0] cx0;
		logic [HALF_W-1:0] cx1;
	} cell_t;

endpackage

`default_nettype wire

// ----- rtl/int64_alu_bidir_shift_unit.sv -----
// ----------------------------------------------------------------------------
// int64_alu_bidir_shift_unit: pipelined 64-bit integer alu
// every action flows through a decode stage, a chain of 64 division cells
// and an output register, so beats leave in the order they came
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | beat
//  req     | in  | req_valid/req_ready | action, operand_a, operand_b
//  rsp     | out | rsp_valid/rsp_ready | result, div_by_zero
//
//  one beat accepted per cycle while rsp is not stalled; each beat passes the
//  decode stage, the 64-cell divider chain and the output register in turn
//  the whole pipe advances together; it holds only while rsp is full and
//  not taken, and req_ready is low for exactly those cycles
//  reset clears all stage valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module int64_alu_bidir_shift_unit
	import i64a_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	logic              adv;
	cell_t             chain [DIV_STEPS+1];
	logic [DATA_W-1:0] quo, rmd, mul, fin;
	logic [4:0]        out_op_q;
	cell_t             last;

	assign adv       = !rsp_valid || rsp_ready;
	assign req_ready = adv;

	i64a_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (req_valid),
		.req      (req),
		.q        (chain[0])
	);

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		i64a_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	always_comb begin
		last = chain[DIV_STEPS];
		quo  = last.qneg ? (DATA_W'(0) - last.dq) : last.dq;
		rmd  = last.rneg ? (DATA_W'(0) - last.rem) : last.rem;
		mul  = last.mlo + {last.cx0 + last.cx1, HALF_W'(0)};
		case (last.action)
			OP_MUL, OP_UMUL:  fin = mul;
			OP_SDIV, OP_UDIV: fin = last.is_div ? quo : last.res;
			OP_SMOD, OP_UMOD: fin = last.is_div ? rmd : last.res;
			default:          fin = last.res;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp.result      <= fin;
			rsp.div_by_zero <= last.dz;
			out_op_q        <= last.action;
		end
	end

	// the pipe only stalls on a full, untaken output
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input stalled with empty output");

	// divide-by-zero only ever comes out of a divide or modulo action
	a_dz_only_div: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.div_by_zero) |-> (out_op_q == OP_SDIV || out_op_q == OP_SMOD
			|| out_op_q == OP_UDIV || out_op_q == OP_UMOD))
		else $error("div_by_zero on non-divide action");

	// a stalled response beat holds its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp) && $stable(out_op_q)))
		else $error("response changed while stalled");

endmodule

`default_nettype wire

// ----- rtl/i64a_prep.sv -----
// ----------------------------------------------------------------------------
// i64a_prep: operand decode stage
// add, subtract, logic, shift, rotate, compare, partial products and divider setup
// ----------------------------------------------------------------------------
`default_nettype none

module i64a_prep
	import i64a_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_valid,
	input  wire req_t  req,
	output cell_t      q
);

	logic [DATA_W-1:0]   a, b, mag, shl, lsr, asr, ma, mb;
	logic [2*DATA_W-1:0] rol_w, ror_w;
	logic                bneg, big, sgn_div, b_zero;
	logic [5:0]          sh;
	logic [DATA_W-1:0]   p_lo, p_x0, p_x1;
	cell_t               d;

	always_comb begin
		a      = req.operand_a;
		b      = req.operand_b;
		bneg   = b[DATA_W-1];
		mag    = bneg ? (DATA_W'(0) - b) : b;
		big    = |mag[DATA_W-1:6];
		sh     = mag[5:0];
		shl    = big ? '0 : (a << sh);
		lsr    = big ? '0 : (a >> sh);
		asr    = big ? {DATA_W{a[DATA_W-1]}} : DATA_W'($signed(a) >>> sh);
		rol_w  = {a, a} << b[5:0];
		ror_w  = {a, a} >> b[5:0];
		b_zero = (b == '0);
		sgn_div = (req.action == OP_SDIV) || (req.action == OP_SMOD);
		ma     = (sgn_div && a[DATA_W-1]) ? (DATA_W'(0) - a) : a;
		mb     = (sgn_div && bneg) ? (DATA_W'(0) - b) : b;
		p_lo   = a[HALF_W-1:0] * b[HALF_W-1:0];
		p_x0   = a[HALF_W-1:0] * b[DATA_W-1:HALF_W];
		p_x1   = a[DATA_W-1:HALF_W] * b[HALF_W-1:0];

		d        = '0;
		d.valid  = in_valid;
		d.action = req.action;
		d.dq     = ma;
		d.dvs    = mb;
		d.rem    = '0;
		d.qneg   = sgn_div && (a[DATA_W-1] ^ bneg);
		d.rneg   = sgn_div && a[DATA_W-1];
		d.mlo    = p_lo;
		d.cx0    = p_x0[HALF_W-1:0];
		d.cx1    = p_x1[HALF_W-1:0];
		case (req.action)
			OP_ADD:  d.res = a + b;
			OP_SUB:  d.res = a - b;
			OP_AND:  d.res = a & b;
			OP_OR:   d.res = a | b;
			OP_XOR:  d.res = a ^ b;
			OP_NOT:  d.res = ~a;
			OP_SSHL: d.res = bneg ? asr : shl;
			OP_SSHR: d.res = bneg ? shl : asr;
			OP_USHL: d.res = bneg ? lsr : shl;
			OP_USHR: d.res = bneg ? shl : lsr;
			OP_ROL:  d.res = rol_w[2*DATA_W-1:DATA_W];
			OP_ROR:  d.res = ror_w[DATA_W-1:0];
			OP_SCMP: d.res = ($signed(a) > $signed(b)) ? DATA_W'(1) :
				((a == b) ? '0 : '1);
			OP_UCMP: d.res = (a > b) ? DATA_W'(1) : ((a == b) ? '0 : '1);
			OP_SDIV, OP_UDIV: begin
				d.dz     = b_zero;
				d.is_div = !b_zero;
				d.res    = '1;
			end
			OP_SMOD, OP_UMOD: begin
				d.dz     = b_zero;
				d.is_div = !b_zero;
				d.res    = a;
			end
			default: d.res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/i64a_div_cell.sv -----
// ----------------------------------------------------------------------------
// i64a_div_cell: one restoring-division step
// develops one quotient bit and passes the whole record to the next cell
// ----------------------------------------------------------------------------
`default_nettype none

module i64a_div_cell
	import i64a_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire cell_t d,
	output cell_t      q
);

	logic [DATA_W+1:0] diff;
	logic              ge;
	cell_t             n;

	always_comb begin
		n    = d;
		// shift the next dividend bit into the partial remainder and trial-subtract
		diff = {1'b0, d.rem, d.dq[DATA_W-1]} - {2'b00, d.dvs};
		ge   = !diff[DATA_W+1];
		n.rem = ge ? diff[DATA_W-1:0] : {d.rem[DATA_W-2:0], d.dq[DATA_W-1]};
		n.dq  = {d.dq[DATA_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= n;
		end
	end

endmodule

`default_nettype wire

// ----- dv/alu_checker.sv -----
// ----------------------------------------------------------------------------
// alu_checker: response checker for the 64-bit integer alu
// watches both channels, computes the expected response of every accepted
// request and compares it with the responses in arrival order
// ----------------------------------------------------------------------------
`default_nettype none

module alu_checker
	import i64a_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic req_ready,
	input  wire req_t req,
	input  wire logic rsp_valid,
	input  wire logic rsp_ready,
	input  wire rsp_t rsp,
	output int        fail_count,
	output int        pending,
	output int        rsp_count
);

	localparam logic [63:0] MSB = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ONES = '1;

	rsp_t expected_rsps[$];

	function automatic logic [63:0] shl(logic [63:0] a, logic [63:0] n);
		return (n >= 64) ? 64'd0 : (a << n);
	endfunction

	function automatic logic [63:0] shr(logic [63:0] a, logic [63:0] n);
		return (n >= 64) ? 64'd0 : (a >> n);
	endfunction

	function automatic logic [63:0] sar(logic [63:0] a, logic [63:0] n);
		if (n >= 64)
			return a[63] ? ONES : 64'd0;
		return a[63] ? ~((~a) >> n) : (a >> n);
	endfunction

	function automatic logic [63:0] cmp_code(logic gt, logic eq);
		if (gt)
			return 64'd1;
		return eq ? 64'd0 : ONES;
	endfunction

	function automatic rsp_t alu_result(req_t r);
		rsp_t o;
		logic [63:0] a, b, mag, ma, mb, mq, mr;
		logic neg;
		logic [5:0] rot;
		a = r.operand_a;
		b = r.operand_b;
		o.result = '0;
		o.div_by_zero = 1'b0;
		neg = b[63];
		mag = neg ? (64'd0 - b) : b;
		rot = b[5:0];
		ma = a[63] ? (64'd0 - a) : a;
		mb = b[63] ? (64'd0 - b) : b;
		case (r.action)
			OP_ADD: o.result = a + b;
			OP_SUB: o.result = a - b;
			OP_MUL, OP_UMUL: o.result = a * b;
			OP_SDIV, OP_SMOD: begin
				if (b == 0) begin
					o.div_by_zero = 1'b1;
					o.result = (r.action == OP_SDIV) ? ONES : a;
				end else begin
					mq = ma / mb;
					mr = ma % mb;
					if (r.action == OP_SDIV)
						o.result = (a[63] != b[63]) ? (64'd0 - mq) : mq;
					else
						o.result = a[63] ? (64'd0 - mr) : mr;
				end
			end
			OP_AND: o.result = a & b;
			OP_OR: o.result = a | b;
			OP_XOR: o.result = a ^ b;
			OP_NOT: o.result = ~a;
			OP_SSHL: o.result = neg ? sar(a, mag) : shl(a, mag);
			OP_SSHR: o.result = neg ? shl(a, mag) : sar(a, mag);
			OP_ROL: o.result = (rot == 0) ? a : ((a << rot) | (a >> (7'd64 - rot)));
			OP_ROR: o.result = (rot == 0) ? a : ((a >> rot) | (a << (7'd64 - rot)));
			OP_SCMP: o.result = cmp_code((a ^ MSB) > (b ^ MSB), a == b);
			OP_UDIV, OP_UMOD: begin
				if (b == 0) begin
					o.div_by_zero = 1'b1;
					o.result = (r.action == OP_UDIV) ? ONES : a;
				end else begin
					o.result = (r.action == OP_UDIV) ? (a / b) : (a % b);
				end
			end
			OP_USHL: o.result = neg ? shr(a, mag) : shl(a, mag);
			OP_USHR: o.result = neg ? shl(a, mag) : shr(a, mag);
			OP_UCMP: o.result = cmp_code(a > b, a == b);
			default: o.result = '0;
		endcase
		return o;
	endfunction

	assign pending = expected_rsps.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			fail_count <= 0;
			rsp_count <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				rsp_count <= rsp_count + 1;
				if (expected_rsps.size() == 0) begin
					$error("response beat with nothing expected: %h", rsp);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.result !== want.result) begin
						$error("result: expected %h, got %h", want.result, rsp.result);
						fail_count <= fail_count + 1;
					end else if (rsp.div_by_zero !== want.div_by_zero) begin
						$error("div_by_zero: expected %b, got %b",
							want.div_by_zero, rsp.div_by_zero);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (req_valid && req_ready)
				expected_rsps.push_back(alu_result(req));
		end
	end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the pipelined 64-bit integer alu
// directed corner requests then random ones, with random gaps on both
// channels; a separate checker predicts and compares every response
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import i64a_pkg::*;

	localparam int N_RANDOM = 1800;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int fail_count, pending, rsp_count;
	int n_sent = 0;
	bit calm = 1'b0;

	always #5 clk = ~clk;

	int64_alu_bidir_shift_unit uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	alu_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.fail_count(fail_count), .pending(pending), .rsp_count(rsp_count)
	);

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// operands biased toward edges, small values and shift-like amounts
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h7fff_ffff_ffff_ffff;
			4: return 64'($urandom_range(0, 130));
			5: return 64'd0 - 64'($urandom_range(1, 130));
			6: return 64'($urandom_range(1, 9));
			default: return rand64();
		endcase
	endfunction

	// valid drops only in idle cycles, so back-to-back beats keep it high
	task automatic send(logic [4:0] act, logic [63:0] a, logic [63:0] b);
		while (!calm && $urandom_range(0, 99) < 18) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= '{action: act, operand_a: a, operand_b: b};
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		n_sent++;
		@(negedge clk);
	endtask

	// receiver stalls at random except in the quiet stretch
	always @(negedge clk)
		rsp_ready <= calm || ($urandom_range(0, 99) >= 18);

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [63:0] edges[6];
		logic [4:0] act;
		int waited;
		edges = '{64'd0, 64'd1, '1, 64'h8000_0000_0000_0000,
			64'h7fff_ffff_ffff_ffff, 64'd64};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// every action on edge operands, then the named corner cases
		for (int op = 0; op < 20; op++)
			send(5'(op), edges[op % 6], edges[(op * 5 + 1) % 6]);
		send(OP_SDIV, 64'h8000_0000_0000_0000, '1);
		send(OP_SMOD, 64'h8000_0000_0000_0000, '1);
		send(OP_UMOD, 64'd77, 64'd0);
		send(OP_SSHR, 64'h8000_0000_0000_0000, 64'd0 - 64'd70);
		send(OP_ROR, rand64(), 64'd0 - 64'd64);
		send(5'd27, '1, '1);
		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= 700 && i < 950);
			act = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(20, 31))
				: 5'($urandom_range(0, 19));
			send(act, pick_operand(), pick_operand());
		end
		req_valid <= 1'b0;
		calm = 1'b0;
		waited = 0;
		while ((pending != 0 || rsp_count != n_sent) && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (80) @(negedge clk);
		$display("covered %0d requests over all actions, unused codes and corner operands",
			n_sent);
		$display("with random gaps on both channels and %0d responses checked", rsp_count);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
